### design/aesbe_pkg.sv
// Package: AES S-box, key size codes, opcodes and register indexes.
`timescale 1ns / 1ps
package aesbe_pkg;

   localparam int KeyWordWidth = 64;
   localparam int RkDepth      = 30;

   localparam logic [1:0] OP_ECB  = 2'd0;
   localparam logic [1:0] OP_CBC  = 2'd1;
   localparam logic [1:0] OP_LOAD = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   localparam logic [2:0] REG_KEY0  = 3'd0;
   localparam logic [2:0] REG_KEY1  = 3'd1;
   localparam logic [2:0] REG_KEY2  = 3'd2;
   localparam logic [2:0] REG_KEY3  = 3'd3;
   localparam logic [2:0] REG_KSIZE = 3'd4;

   localparam logic [1:0] KS_128 = 2'd0;
   localparam logic [1:0] KS_192 = 2'd1;

   typedef logic [7:0] byte_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic byte_type xtime(input byte_type a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // 32-bit word, byte 0 in bits 7:0
   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

### design/aesbe_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module aesbe_ram #(
   parameter int Width = 64,
   parameter int Depth = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/aesbe_round.sv
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
`timescale 1ns / 1ps
module aesbe_round (
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         mix_en,
   output logic [127:0] state_out
);
   import aesbe_pkg::*;

   byte_type sb [16];
   byte_type sr [16];
   byte_type mc [16];
   byte_type a0, a1, a2, a3;

   always_comb begin
      a0 = '0; a1 = '0; a2 = '0; a3 = '0;
      for (int i = 0; i < 16; i++) begin
         sb[i] = SBOX[state_in[8*i +: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sr[i + 4*c] = sb[i + 4*((c + i) % 4)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
         mc[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         mc[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         mc[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         mc[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      for (int i = 0; i < 16; i++) begin
         state_out[8*i +: 8] = (mix_en ? mc[i] : sr[i]) ^ round_key[8*i +: 8];
      end
   end
endmodule

### design/aes_block_encrypt_ecb_cbc.sv
// Top level: AES-128/192/256 ECB/CBC block encryptor with iterative round unit.
`timescale 1ns / 1ps
// Usage:
//  - csr_ channel writes key words (index 0..3) and key size (index 4) while
//    idle; a write to index 0..4 marks the key schedule stale.
//  - req_ channel takes one 128-bit block with an opcode: ECB, CBC or load IV.
//  - rsp_ channel returns one result per request, last_out mirrors last_block.
// Timing:
//  - The first encrypt after reset or a key write first expands the schedule,
//    one 32-bit key word per cycle.
//  - Each 128-bit round key of an encrypt is read as two 64-bit entries from
//    the round-key RAM; the shared round unit applies a round once both halves
//    are held.
//  - With the receiver ready, a new request is taken in the cycle the previous
//    result leaves.
//  - Load and no-op requests go straight to the output register.
//  - One request is in flight at a time; req_ready is low while busy, while
//    a result waits on a stalled receiver, or while csr_valid is high.
// Reset: clears control, the chaining value and marks the key schedule stale.
module aes_block_encrypt_ecb_cbc #(
   parameter int RkDepth = aesbe_pkg::RkDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_block_lo,
   input  logic [63:0] req_block_hi,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_lo,
   output logic [63:0] rsp_result_hi,
   output logic        rsp_last_out
);
   import aesbe_pkg::*;

   localparam int AW = $clog2(RkDepth);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXP   = 3'd1;
   localparam logic [2:0] S_RD0   = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [63:0]  key_ff [4];
   logic [1:0]   ksize_ff;
   logic         keys_ok_ff, keys_ok_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] st_ff, st_in;
   logic [1:0]   op_ff, op_in;
   logic         last_ff, last_in;
   logic [3:0]   round_ff, round_in;
   logic [5:0]   wi_ff, wi_in;
   logic [255:0] win_ff, win_in;   // sliding window of last Nk words
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  wlo_ff, wlo_in;   // pending low half of a 64-bit key entry
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] res_ff, res_in;
   logic         rlast_ff, rlast_in;

   logic [3:0]  nk, nr;
   logic [5:0]  total;
   logic [3:0]  kcnt_ff, kcnt_in;  // wi mod nk
   logic [31:0] tw, neww, prevw, oldw;
   logic        ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [63:0] ram_wd, rk_lo, rk_hi_ff, rk_hi_in;
   logic [127:0] rnd_out;
   logic [127:0] blk;

   always_comb begin
      unique case (ksize_ff)
         KS_128:  begin nk = 4'd4; nr = 4'd10; end
         KS_192:  begin nk = 4'd6; nr = 4'd12; end
         default: begin nk = 4'd8; nr = 4'd14; end
      endcase
      total = 6'(4 * (nr + 4'd1));
   end

   aesbe_ram #(.Width(64), .Depth(RkDepth)) u_rk (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(rk_lo)
   );

   aesbe_round u_round (
      .state_in(st_ff), .round_key({rk_hi_ff, rk_lo}),
      .mix_en(round_ff != nr), .state_out(rnd_out)
   );

   assign csr_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_lo = res_ff[63:0];
   assign rsp_result_hi = res_ff[127:64];
   assign rsp_last_out = rlast_ff;

   // key expansion word step
   always_comb begin
      prevw = win_ff[32*(nk-1) +: 32];
      oldw  = win_ff[31:0];
      tw    = prevw;
      if (kcnt_ff == 4'd0) begin
         tw = sub_word({prevw[7:0], prevw[31:8]}) ^ {24'd0, rcon_ff};
      end else if (nk == 4'd8 && kcnt_ff == 4'd4) begin
         tw = sub_word(prevw);
      end
      neww = oldw ^ tw;
   end

   assign blk = {req_block_hi, req_block_lo};

   always_comb begin
      state_in = state_ff;
      keys_ok_in = keys_ok_ff;
      chain_in = chain_ff;
      st_in = st_ff;
      op_in = op_ff;
      last_in = last_ff;
      round_in = round_ff;
      wi_in = wi_ff;
      win_in = win_ff;
      rcon_in = rcon_ff;
      wlo_in = wlo_ff;
      kcnt_in = kcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      res_in = res_ff;
      rlast_in = rlast_ff;
      ram_we = 1'b0;
      ram_wa = AW'(wi_ff[5:1]);
      ram_wd = '0;
      ram_ra = AW'(0);
      rk_hi_in = rk_lo;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               if (csr_index <= REG_KSIZE) keys_ok_in = 1'b0;
            end else if (req_valid && req_ready) begin
               op_in = req_opcode;
               last_in = req_last_block;
               st_in = (req_opcode == OP_CBC) ? blk ^ chain_ff : blk;
               case (req_opcode)
                  OP_LOAD: begin
                     chain_in = blk; res_in = blk;
                     rlast_in = req_last_block; rsp_valid_in = 1'b1;
                  end
                  OP_NOP: begin
                     res_in = '0; rlast_in = req_last_block; rsp_valid_in = 1'b1;
                  end
                  default: begin
                     if (keys_ok_ff) begin
                        state_in = S_RD0;
                        ram_ra = AW'(1);
                     end else begin
                        state_in = S_EXP;
                        wi_in = '0;
                        kcnt_in = '0;
                        rcon_in = 8'h01;
                        win_in = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};
                     end
                  end
               endcase
            end
         end
         S_EXP: begin
            // first Nk words come straight from the key, then one new word per cycle
            if (wi_ff < 6'(nk)) begin
               ram_wd = {win_ff[32*wi_ff[2:0] +: 32], wlo_ff};
               wlo_in = win_ff[32*wi_ff[2:0] +: 32];
            end else begin
               ram_wd = {neww, wlo_ff};
               wlo_in = neww;
               win_in = win_ff >> 32;
               win_in[32*(nk-1) +: 32] = neww;
               if (kcnt_ff == 4'd0) rcon_in = xtime(rcon_ff);
               kcnt_in = (kcnt_ff == nk - 4'd1) ? 4'd0 : kcnt_ff + 4'd1;
            end
            ram_we = wi_ff[0];
            wi_in = wi_ff + 6'd1;
            if (wi_ff == total - 6'd1) begin
               keys_ok_in = 1'b1;
               state_in = S_RD0;
               ram_ra = AW'(1);
            end
         end
         S_RD0: begin
            // hold the high half of round key 0, fetch its low half
            ram_ra = AW'(0);
            rk_hi_in = rk_lo;
            round_in = 4'd0;
            wi_in[0] = 1'b1;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            // each round fetches the high half, then the low half
            ram_ra = AW'(0);
            state_in = S_ROUND;
            round_in = round_ff;
            if (wi_ff[0] == 1'b0) begin
               rk_hi_in = rk_lo;
               ram_ra = AW'(2 * round_ff);
               wi_in[0] = 1'b1;
            end else begin
               wi_in[0] = 1'b0;
               rk_hi_in = rk_hi_ff;
               if (round_ff == 4'd0) begin
                  st_in = st_ff ^ {rk_hi_ff, rk_lo};
               end else begin
                  st_in = rnd_out;
               end
               if (round_ff == nr) begin
                  state_in = S_OUT;
               end else begin
                  round_in = round_ff + 4'd1;
                  ram_ra = AW'(2 * (round_ff + 4'd1) + 1);
               end
            end
         end
         S_OUT: begin
            res_in = st_ff;
            rlast_in = last_ff;
            rsp_valid_in = 1'b1;
            if (op_ff == OP_CBC) chain_in = st_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         keys_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff <= '0;
         ksize_ff <= KS_128;
         wi_ff <= '0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         keys_ok_ff <= keys_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff <= chain_in;
         wi_ff <= (state_in == S_RD0) ? '0 : wi_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KEY0:  key_ff[0] <= csr_data;
               REG_KEY1:  key_ff[1] <= csr_data;
               REG_KEY2:  key_ff[2] <= csr_data;
               REG_KEY3:  key_ff[3] <= csr_data;
               REG_KSIZE: ksize_ff <= csr_data[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      op_ff <= op_in;
      last_ff <= last_in;
      round_ff <= round_in;
      win_ff <= win_in;
      rcon_ff <= rcon_in;
      wlo_ff <= wlo_in;
      kcnt_ff <= kcnt_in;
      res_ff <= res_in;
      rlast_ff <= rlast_in;
      rk_hi_ff <= rk_hi_in;
   end

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && !rsp_ready |=> rsp_valid_ff;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("response dropped");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready while busy");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND |-> round_ff <= nr) else $error("round overrun");

   a_keys_after_exp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXP && state_in == S_RD0 |=> keys_ok_ff) else $error("keys not marked");
endmodule

### tb/sv/testbench.sv
// Testbench for the AES ECB/CBC block encryptor: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module testbench;
   import aesbe_pkg::*;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
      logic        last;
   } cipher_out_type;

   // Golden AES encryptor with its own key registers, key schedule and chaining value.
   class cipher_scoreboard;
      logic [63:0] key_word [4];
      logic [1:0]  key_size;
      logic [63:0] chain_lo, chain_hi;
      logic [7:0]  sched [240];
      bit          sched_stale;
      int unsigned rounds;
      cipher_out_type pending_q [$];
      int          errors;

      function new();
         foreach (key_word[i]) key_word[i] = '0;
         key_size = KS_128;
         chain_lo = '0;
         chain_hi = '0;
         sched_stale = 1;
         rounds = 10;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [63:0] data);
         case (index)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
               key_word[index[1:0]] = data;
               sched_stale = 1;
            end
            REG_KSIZE: begin
               key_size = data[1:0];
               sched_stale = 1;
            end
            default: ;
         endcase
      endfunction

      function logic [7:0] dbl(logic [7:0] a);
         return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      endfunction

      function void build_schedule();
         int unsigned nk, ks, i, j;
         logic [7:0] t [4];
         logic [7:0] rc, tmp;
         ks = (key_size == 2'd3) ? 2 : key_size;
         nk = 4 + 2 * ks;
         rounds = 10 + 2 * ks;
         rc = 8'h01;
         for (i = 0; i < 240; i++) sched[i] = '0;
         for (i = 0; i < 32; i++) sched[i] = key_word[i / 8][8 * (i % 8) +: 8];
         for (i = nk; i < 4 * (rounds + 1); i++) begin
            for (j = 0; j < 4; j++) t[j] = sched[4 * (i - 1) + j];
            if (i % nk == 0) begin
               tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
               for (j = 0; j < 4; j++) t[j] = SBOX[t[j]];
               t[0] ^= rc;
               rc = dbl(rc);
            end else if (nk > 6 && i % nk == 4) begin
               for (j = 0; j < 4; j++) t[j] = SBOX[t[j]];
            end
            for (j = 0; j < 4; j++) sched[4 * i + j] = sched[4 * (i - nk) + j] ^ t[j];
         end
         sched_stale = 0;
      endfunction

      function logic [127:0] encrypt(logic [127:0] blk);
         logic [7:0] s [16];
         logic [7:0] o [16];
         logic [7:0] a0, a1, a2, a3;
         int unsigned r, c, i;
         logic [127:0] res;
         for (i = 0; i < 16; i++) s[i] = blk[8 * i +: 8] ^ sched[i];
         for (r = 1; r <= rounds; r++) begin
            for (i = 0; i < 16; i++) o[i] = SBOX[s[i]];
            for (c = 0; c < 4; c++)
               for (i = 0; i < 4; i++) s[i + 4 * c] = o[i + 4 * ((c + i) % 4)];
            if (r != rounds) begin
               for (c = 0; c < 4; c++) begin
                  a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                  s[4 * c]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                  s[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                  s[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                  s[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
               end
            end
            for (i = 0; i < 16; i++) s[i] ^= sched[16 * r + i];
         end
         for (i = 0; i < 16; i++) res[8 * i +: 8] = s[i];
         return res;
      endfunction

      function void note_request(logic [1:0] op, logic [63:0] lo, logic [63:0] hi, logic last);
         cipher_out_type e;
         logic [127:0] ct;
         e.last = last;
         case (op)
            OP_LOAD: begin
               chain_lo = lo;
               chain_hi = hi;
               e.lo = lo;
               e.hi = hi;
            end
            OP_NOP: begin
               e.lo = '0;
               e.hi = '0;
            end
            default: begin
               if (sched_stale) build_schedule();
               if (op == OP_CBC) ct = encrypt({hi ^ chain_hi, lo ^ chain_lo});
               else ct = encrypt({hi, lo});
               e.lo = ct[63:0];
               e.hi = ct[127:64];
               if (op == OP_CBC) begin
                  chain_lo = e.lo;
                  chain_hi = e.hi;
               end
            end
         endcase
         pending_q.push_back(e);
      endfunction

      function void check_response(logic [63:0] lo, logic [63:0] hi, logic last);
         cipher_out_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response lo=%h hi=%h last=%b", $time, lo, hi, last);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (lo !== e.lo) begin
            $display("%0t: result_lo expected %h actual %h", $time, e.lo, lo);
            errors++;
         end
         if (hi !== e.hi) begin
            $display("%0t: result_hi expected %h actual %h", $time, e.hi, hi);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last_out expected %b actual %b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   localparam int StallLimit = 5000;

   logic        clock, reset;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;
   logic        req_valid, req_ready;
   logic [1:0]  req_opcode;
   logic [63:0] req_block_lo, req_block_hi;
   logic        req_last_block;
   logic        rsp_valid, rsp_ready;
   logic [63:0] rsp_result_lo, rsp_result_hi;
   logic        rsp_last_out;

   cipher_scoreboard sb;
   int send_idle, recv_idle, hold_cycles, quiet_cycles;

   aes_block_encrypt_ecb_cbc DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Receiver: decide ready at the falling edge, check at the rising edge.
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_result_lo, rsp_result_hi, rsp_last_out);
   end

   // Watchdog on cycles with no handshake at all.
   always @(posedge clock) begin
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] index, logic [63:0] data);
      @(negedge clock);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_req(logic [1:0] op, logic [63:0] lo, logic [63:0] hi, logic last);
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid      <= 1;
      req_opcode     <= op;
      req_block_lo   <= lo;
      req_block_hi   <= hi;
      req_last_block <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, lo, hi, last);
   endtask

   // Lower valid and wait until every expected result is back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic rekey(logic [1:0] size);
      for (int i = 0; i < 4; i++) write_reg(3'(i), rnd64());
      write_reg(REG_KSIZE, {62'd0, size});
   endtask

   // Mostly CBC chains opened by an IV load, with ECB blocks and no-ops mixed in.
   task automatic random_traffic(int count);
      int sent, len, kind;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9);
         if (kind < 6) begin
            len = $urandom_range(1, 8);
            send_req(OP_LOAD, rnd64(), rnd64(), 1'($urandom_range(1)));
            for (int i = 0; i < len; i++)
               send_req(OP_CBC, rnd64(), rnd64(), i == len - 1);
            sent += len + 1;
         end else if (kind < 9) begin
            send_req(OP_ECB, rnd64(), rnd64(), 1'($urandom_range(1)));
            sent++;
         end else begin
            send_req(OP_NOP, rnd64(), rnd64(), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      send_idle = 0;
      recv_idle = 0;
      hold_cycles = 0;
      quiet_cycles = 0;
      reset = 1;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 0;
      req_opcode = OP_NOP;
      req_block_lo = '0;
      req_block_hi = '0;
      req_last_block = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset key, standard key, extremes, every opcode and key size.
      send_req(OP_ECB, '0, '0, 0);
      send_req(OP_CBC, '0, '0, 1);
      write_reg(REG_KEY0, 64'h0706050403020100);
      write_reg(REG_KEY1, 64'h0f0e0d0c0b0a0908);
      write_reg(REG_KEY2, 64'h1716151413121110);
      write_reg(REG_KEY3, 64'h1f1e1d1c1b1a1918);
      send_req(OP_ECB, 64'h7766554433221100, 64'hffeeddccbbaa9988, 1);
      send_req(OP_ECB, '1, '1, 0);
      send_req(OP_LOAD, '1, '0, 0);
      send_req(OP_CBC, '0, '1, 0);
      send_req(OP_CBC, '1, '1, 1);
      send_req(OP_NOP, '1, '1, 1);
      send_req(OP_NOP, '0, '0, 0);
      drain();
      for (int ks = 1; ks < 4; ks++) begin
         write_reg(REG_KSIZE, 64'(ks));
         send_req(OP_ECB, 64'h7766554433221100, 64'hffeeddccbbaa9988, 1);
         send_req(OP_CBC, '1, '0, 0);
         drain();
      end
      // Out-of-range indexes must leave the key alone.
      write_reg(3'd5, '1);
      write_reg(3'd6, '1);
      write_reg(3'd7, '1);
      send_req(OP_ECB, '0, '0, 1);
      drain();
      write_reg(REG_KEY0, '1);
      write_reg(REG_KEY1, '1);
      write_reg(REG_KEY2, '1);
      write_reg(REG_KEY3, '1);
      write_reg(REG_KSIZE, 64'(KS_128));
      send_req(OP_ECB, '1, '1, 0);
      send_req(OP_ECB, '0, '0, 1);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 8 : (phase == 1) ? 60 : 0;
         recv_idle = (phase == 0) ? 60 : (phase == 1) ? 8 : 0;
         for (int seg = 0; seg < 2; seg++) begin
            rekey(2'((2 * phase + seg) % 4));
            if (phase == 2 && seg == 0) hold_cycles = 400;
            random_traffic(280);
            drain();
         end
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
